// File: src/length_prefixed_frame_parser_macros.svh
// Assertion helpers for the frame parser. Clock aclk, reset aresetn (active low).
`ifndef LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define LPFP_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPFP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lpfp_pkg.sv
`default_nettype none

package lpfp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 1024;
    localparam int LEN_W             = 16;   // declared length / byte position
    localparam int CLEN_W            = 11;   // completed length
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 16;

    localparam logic [7:0]        SYNC_FIRST_RST    = 8'h55;
    localparam logic [7:0]        SYNC_SECOND_RST   = 8'hAA;
    localparam logic [CLEN_W-1:0] PAYLOAD_LIMIT_RST = 11'd1024;
    localparam logic [15:0]       GAP_LIMIT_RST     = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST    = 8'd0,
        REG_SYNC_SECOND   = 8'd1,
        REG_PAYLOAD_LIMIT = 8'd2,
        REG_GAP_LIMIT     = 8'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HDR2 = 3'd1,
        PH_CMD  = 3'd2,
        PH_LENH = 3'd3,
        PH_LENL = 3'd4,
        PH_BODY = 3'd5,
        PH_SUM  = 3'd6
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic [31:0] arrival_ms;
        logic [9:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic              frame_done;
        logic [7:0]        frame_command;
        logic [CLEN_W-1:0] frame_length;
        logic              sum_error;
        logic              malformed;
        logic              partial_dropped;
        logic [7:0]        read_data;
        logic [31:0]       good_frames;
        logic [31:0]       malformed_total;
        logic [31:0]       sum_error_total;
        logic [31:0]       dropped_total;
        logic [31:0]       byte_total;
    } out_item_t;

    typedef struct packed {
        logic [7:0]        sync_first;
        logic [7:0]        sync_second;
        logic [CLEN_W-1:0] payload_limit;
        logic [15:0]       gap_limit_ms;
    } cfg_t;

    // Per-byte decision from the framer to the top level.
    typedef struct packed {
        logic              done;
        logic [7:0]        command;
        logic [CLEN_W-1:0] length;
        logic              sum_err;
        logic              mal;
        logic              dropped;
        logic              wr_en;
        logic [LEN_W-1:0]  wr_pos;
        logic [7:0]        wr_data;
    } evt_t;

endpackage

`default_nettype wire

// File: src/lpfp_ram.sv
`default_nettype none

module lpfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/lpfp_framer.sv
`default_nettype none

// Header hunt / length / payload / checksum sequencer with gap timeout.
module lpfp_framer #(
    parameter int PAYLOAD_DEPTH = lpfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lpfp_pkg::cfg_t    cfg,
    input  wire logic              fire,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [31:0]       arrival_ms,
    output lpfp_pkg::evt_t         evt
);

    localparam int LW = lpfp_pkg::LEN_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(PAYLOAD_DEPTH);

    lpfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic [31:0]   last_reg, last_next;

    lpfp_pkg::phase_t cur_phase;
    logic [31:0]   gap;
    logic          drop;
    logic [LW-1:0] limit;
    logic [LW-1:0] len_full;
    logic [LW-1:0] pos_inc;
    logic [7:0]    sum_add;

    always_comb begin
        gap       = arrival_ms - last_reg;
        drop      = (phase_reg != lpfp_pkg::PH_IDLE) && (last_reg != '0)
                    && (gap > {16'b0, cfg.gap_limit_ms});
        cur_phase = drop ? lpfp_pkg::PH_IDLE : phase_reg;
        limit     = (LW'(cfg.payload_limit) > DEPTH_L) ? DEPTH_L : LW'(cfg.payload_limit);
        len_full  = {len_reg[LW-1:8], rx_byte};
        pos_inc   = pos_reg + LW'(1);
        sum_add   = sum_reg + rx_byte;
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        last_next  = last_reg;
        if (fire) begin
            last_next = arrival_ms;
            if (drop) begin
                cmd_next = '0;
                len_next = '0;
                pos_next = '0;
                sum_next = '0;
            end
            unique case (cur_phase)
                lpfp_pkg::PH_IDLE: begin
                    if (rx_byte == cfg.sync_first) phase_next = lpfp_pkg::PH_HDR2;
                    else phase_next = lpfp_pkg::PH_IDLE;
                end
                lpfp_pkg::PH_HDR2: begin
                    if (rx_byte == cfg.sync_second) phase_next = lpfp_pkg::PH_CMD;
                    else if (rx_byte == cfg.sync_first) phase_next = lpfp_pkg::PH_HDR2;
                    else phase_next = lpfp_pkg::PH_IDLE;
                end
                lpfp_pkg::PH_CMD: begin
                    cmd_next   = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = lpfp_pkg::PH_LENH;
                end
                lpfp_pkg::PH_LENH: begin
                    len_next   = {rx_byte, 8'b0};
                    sum_next   = sum_add;
                    phase_next = lpfp_pkg::PH_LENL;
                end
                lpfp_pkg::PH_LENL: begin
                    len_next = len_full;
                    sum_next = sum_add;
                    pos_next = '0;
                    if (len_full == '0) phase_next = lpfp_pkg::PH_SUM;
                    else if (len_full > limit) phase_next = lpfp_pkg::PH_IDLE;
                    else phase_next = lpfp_pkg::PH_BODY;
                end
                lpfp_pkg::PH_BODY: begin
                    sum_next = sum_add;
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg) phase_next = lpfp_pkg::PH_SUM;
                end
                lpfp_pkg::PH_SUM: begin
                    phase_next = lpfp_pkg::PH_IDLE;
                    cmd_next   = '0;
                    len_next   = '0;
                    pos_next   = '0;
                    sum_next   = '0;
                end
                default: begin
                    phase_next = lpfp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        evt         = '0;
        evt.wr_pos  = pos_reg;
        evt.wr_data = rx_byte;
        evt.length  = len_reg[lpfp_pkg::CLEN_W-1:0];
        if (fire) begin
            evt.dropped = drop;
            unique case (cur_phase)
                lpfp_pkg::PH_IDLE: evt.mal = (rx_byte != cfg.sync_first);
                lpfp_pkg::PH_HDR2: evt.mal = (rx_byte != cfg.sync_second);
                lpfp_pkg::PH_CMD:  evt.mal = 1'b0;
                lpfp_pkg::PH_LENH: evt.mal = 1'b0;
                lpfp_pkg::PH_LENL: evt.mal = (len_full != '0) && (len_full > limit);
                lpfp_pkg::PH_BODY: evt.wr_en = (pos_reg < DEPTH_L);
                lpfp_pkg::PH_SUM: begin
                    evt.done    = (sum_reg == rx_byte);
                    evt.sum_err = (sum_reg != rx_byte);
                    evt.command = (sum_reg == rx_byte) ? cmd_reg : 8'd0;
                end
                default: evt.mal = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lpfp_pkg::PH_IDLE;
            cmd_reg   <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            last_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

// File: src/length_prefixed_frame_parser.sv
`default_nettype none

// Length-prefixed frame parser. Each input item either feeds one received
// byte with its ms arrival time (kind 0) or reads one byte of the payload
// buffer (kind 1); every item returns exactly one result item carrying the
// per-byte flags, the last good frame's length and the five wrapping event
// counters. Frames are sync_first, sync_second, command, length high, length
// low, payload, and a checksum equal to the mod-256 sum of command, length
// bytes and payload. Throughput is one item per clock unless the result
// channel stalls: the framer state is a handful of flops with combinational
// next state, and the payload buffer is a single RAM with one write port
// (payload bytes) and one registered read port (read items), so both kinds
// can stream back to back. The result path has two register stages: stage 1
// and the RAM read load when an item is accepted, the output register when
// stage 1 advances. No clearing pass runs after reset; buffer entries beyond
// the last good frame's length read back as zero.
// Configuration writes are always taken (cfg_ready is tied high) and should
// only be issued while idle.
module length_prefixed_frame_parser #(
    parameter int PAYLOAD_DEPTH = lpfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input item channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire lpfp_pkg::in_item_t                s_item,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output lpfp_pkg::out_item_t                    m_item,
    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lpfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lpfp_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "length_prefixed_frame_parser_macros.svh"

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam int LW = lpfp_pkg::LEN_W;
    localparam int CW = lpfp_pkg::CLEN_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(PAYLOAD_DEPTH);

    // ---------------- configuration registers ----------------
    lpfp_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lpfp_pkg::REG_SYNC_FIRST:    cfg_next.sync_first    = cfg_data[7:0];
                lpfp_pkg::REG_SYNC_SECOND:   cfg_next.sync_second   = cfg_data[7:0];
                lpfp_pkg::REG_PAYLOAD_LIMIT: cfg_next.payload_limit = cfg_data[CW-1:0];
                lpfp_pkg::REG_GAP_LIMIT:     cfg_next.gap_limit_ms  = cfg_data[15:0];
                default:                     cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    // ---------------- handshake / pipeline control ----------------
    // Stage 1 waits on the RAM read; stage 2 is the output register.
    logic                 v1_reg, v1_next;
    logic                 m_valid_reg, m_valid_next;
    lpfp_pkg::out_item_t  s1_reg, s1_next;
    logic                 s1_hit_reg, s1_hit_next;
    lpfp_pkg::out_item_t  m_item_reg, m_item_next;
    logic                 s1_advance;
    logic                 accept, byte_fire, read_fire;

    assign s1_advance = v1_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !v1_reg || !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign byte_fire  = accept && !s_item.kind;
    assign read_fire  = accept && s_item.kind;

    // ---------------- framer ----------------
    lpfp_pkg::evt_t evt;

    lpfp_framer #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fire       (byte_fire),
        .rx_byte    (s_item.rx_byte),
        .arrival_ms (s_item.arrival_ms),
        .evt        (evt)
    );

    // ---------------- payload buffer ----------------
    // Writes and reads sit on different accepted items, so a read always
    // sees every earlier write; no forwarding path is needed.
    logic [LW-1:0] rd_idx_ext;
    logic [7:0]    ram_rdata;

    assign rd_idx_ext = LW'(s_item.read_index);

    lpfp_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (evt.wr_en),
        .waddr (evt.wr_pos[AW-1:0]),
        .wdata (evt.wr_data),
        .re    (read_fire),
        .raddr (rd_idx_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- counters and completed length ----------------
    logic [CW-1:0] clen_reg, clen_next;
    logic [31:0]   good_reg, good_next;
    logic [31:0]   mal_reg, mal_next;
    logic [31:0]   sumerr_reg, sumerr_next;
    logic [31:0]   drop_reg, drop_next;
    logic [31:0]   byte_total_reg, byte_total_next;

    always_comb begin
        clen_next       = evt.done ? evt.length : clen_reg;
        good_next       = good_reg + 32'(evt.done);
        mal_next        = mal_reg + 32'(evt.mal);
        sumerr_next     = sumerr_reg + 32'(evt.sum_err);
        drop_next       = drop_reg + 32'(evt.dropped);
        byte_total_next = byte_total_reg + 32'(byte_fire);
    end

    // ---------------- result assembly ----------------
    always_comb begin
        v1_next     = v1_reg;
        s1_next     = s1_reg;
        s1_hit_next = s1_hit_reg;
        if (accept) begin
            v1_next                 = 1'b1;
            s1_next.frame_done      = evt.done;
            s1_next.frame_command   = evt.command;
            s1_next.frame_length    = clen_next;
            s1_next.sum_error       = evt.sum_err;
            s1_next.malformed       = evt.mal;
            s1_next.partial_dropped = evt.dropped;
            s1_next.read_data       = 8'd0;          // filled from RAM in stage 2
            s1_next.good_frames     = good_next;
            s1_next.malformed_total = mal_next;
            s1_next.sum_error_total = sumerr_next;
            s1_next.dropped_total   = drop_next;
            s1_next.byte_total      = byte_total_next;
            // only in-range positions of the last good frame read back
            s1_hit_next = s_item.kind
                          && ({1'b0, s_item.read_index} < clen_reg)
                          && (rd_idx_ext < DEPTH_L);
        end else if (s1_advance) begin
            v1_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (s1_advance) begin
            m_valid_next          = 1'b1;
            m_item_next           = s1_reg;
            m_item_next.read_data = s1_hit_reg ? ram_rdata : 8'd0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first    <= lpfp_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second   <= lpfp_pkg::SYNC_SECOND_RST;
            cfg_reg.payload_limit <= lpfp_pkg::PAYLOAD_LIMIT_RST;
            cfg_reg.gap_limit_ms  <= lpfp_pkg::GAP_LIMIT_RST;
            v1_reg                <= 1'b0;
            m_valid_reg           <= 1'b0;
            clen_reg              <= '0;
            good_reg              <= '0;
            mal_reg               <= '0;
            sumerr_reg            <= '0;
            drop_reg              <= '0;
            byte_total_reg        <= '0;
        end else begin
            cfg_reg        <= cfg_next;
            v1_reg         <= v1_next;
            m_valid_reg    <= m_valid_next;
            clen_reg       <= clen_next;
            good_reg       <= good_next;
            mal_reg        <= mal_next;
            sumerr_reg     <= sumerr_next;
            drop_reg       <= drop_next;
            byte_total_reg <= byte_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg     <= s1_next;
        s1_hit_reg <= s1_hit_next;
        m_item_reg <= m_item_next;
    end

    // ---------------- checks ----------------
    `LPFP_CHECK_NOW(a_one_outcome, m_valid,
        $onehot0({m_item.frame_done, m_item.sum_error, m_item.malformed}),
        "more than one frame outcome on a result")
    `LPFP_CHECK_NOW(a_cmd_only_done, m_valid && !m_item.frame_done,
        m_item.frame_command == 8'd0, "command shown without a good frame")
    `LPFP_CHECK_NEXT(a_ram_hold, v1_reg && s1_hit_reg && !s1_advance,
        $stable(ram_rdata), "RAM read data changed while stage 1 stalled")
    `LPFP_CHECK_NEXT(a_byte_count, aresetn && byte_fire,
        byte_total_reg == $past(byte_total_reg) + 32'd1,
        "byte counter missed an accepted byte")

endmodule

`default_nettype wire
